### hdl/bmp_pkg.sv
// Shared types and constants for the binomial-modulo-prime block.
package bmp_pkg;

  localparam int ArgW = 18;
  localparam int ResW = 30;
  localparam int ExpW = 5;
  localparam logic [ResW-1:0] MOD_P = 30'd1000000007;

  typedef logic [ArgW-1:0] arg_t;
  typedef logic [ResW-1:0] res_t;

  // Request to the three-lane divider: all lanes share one divisor.
  typedef struct packed {
    logic            go;
    arg_t            divisor;
    logic [2:0][ArgW-1:0] dividend;
  } div_req_t;

  // Result from the three-lane divider.
  typedef struct packed {
    logic            done;
    logic [2:0][ArgW-1:0] quotient;
  } div_rsp_t;

endpackage

### hdl/bmp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module bmp_ram #(
  parameter int Width = 1,
  parameter int Depth = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/bmp_div.sv
// Three-lane restoring divider, one quotient bit per lane per cycle.
module bmp_div
  import bmp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [2:0][ArgW-1:0] x_r, x_nxt;
  logic [2:0][ArgW-1:0] rem_r, rem_nxt;
  arg_t                 d_r, d_nxt;
  logic [ExpW-1:0]      cnt_r, cnt_nxt;
  logic                 run_r, run_nxt;
  logic                 done_r, done_nxt;
  logic [2:0][ArgW:0]   trial;

  always_comb begin
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    for (int l = 0; l < 3; l++) begin
      trial[l] = {rem_r[l], x_r[l][ArgW-1]};
    end
    if (req.go) begin
      x_nxt   = req.dividend;
      rem_nxt = '0;
      d_nxt   = req.divisor;
      cnt_nxt = ExpW'(ArgW - 1);
      run_nxt = 1'b1;
    end else if (run_r) begin
      for (int l = 0; l < 3; l++) begin
        if (trial[l] >= {1'b0, d_r}) begin
          rem_nxt[l] = ArgW'(trial[l] - {1'b0, d_r});
          x_nxt[l]   = {x_r[l][ArgW-2:0], 1'b1};
        end else begin
          rem_nxt[l] = trial[l][ArgW-1:0];
          x_nxt[l]   = {x_r[l][ArgW-2:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    x_r   <= x_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = x_r;

endmodule

### hdl/bmp_mulmod.sv
// Bit-serial modular multiplier: a * b mod MOD_P, one bit of b per cycle.
module bmp_mulmod
  import bmp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic go,
  input  res_t a,
  input  arg_t b,
  output logic done,
  output res_t res
);

  res_t            a_r, a_nxt;
  arg_t            b_r, b_nxt;
  res_t            r_r, r_nxt;
  logic [ExpW-1:0] cnt_r, cnt_nxt;
  logic            run_r, run_nxt;
  logic            done_r, done_nxt;
  logic [ResW+1:0] t;

  localparam logic [ResW+1:0] P1 = {2'b00, MOD_P};
  localparam logic [ResW+1:0] P2 = {1'b0, MOD_P, 1'b0};

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    r_nxt    = r_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    // Doubling plus one addend stays below three times the modulus.
    t = {1'b0, r_r, 1'b0} + (b_r[ArgW-1] ? {2'b00, a_r} : '0);
    if (go) begin
      a_nxt   = a;
      b_nxt   = b;
      r_nxt   = '0;
      cnt_nxt = ExpW'(ArgW - 1);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (t >= P2) begin
        r_nxt = ResW'(t - P2);
      end else if (t >= P1) begin
        r_nxt = ResW'(t - P1);
      end else begin
        r_nxt = t[ResW-1:0];
      end
      b_nxt   = {b_r[ArgW-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    r_r   <= r_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign res  = r_r;

endmodule

### hdl/binomial_mod_prime.sv
// Top level: C(n,k) mod 1000000007 by a prime sieve and Legendre exponents.
//
// A query is transferred at a rising edge with start high and busy low; it
// carries in_n_total and in_k_chosen. Exactly one result follows, shown for
// one cycle with out_valid high: out_binom_mod and out_bad_args. The
// receiver cannot stall, so the result is taken in that cycle.
// After reset the block fills a one-bit prime table: it writes 0 to
// entries 0 and 1 and 1 to all others, then sieves out the composites;
// busy is high throughout. A bad query (k > n or n >= N_MAX) answers in
// the cycle after its transfer. A good query with n >= 2 walks q = 2..n,
// reading each value from the table; for each prime it runs the
// three-lane divider once per power of q not above n, then the bit-serial
// modular multiplier once for each unit of the exponent. busy falls when
// the result is shown, so a new query may be transferred in the strobe
// cycle.
module binomial_mod_prime
  import bmp_pkg::*;
#(
  parameter int N_MAX = 262144
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  logic [ArgW-1:0] in_n_total,
  input  logic [ArgW-1:0] in_k_chosen,
  output logic            out_valid,
  output logic [ResW-1:0] out_binom_mod,
  output logic            out_bad_args
);

  localparam int AW = $clog2(N_MAX);
  localparam int XW = (AW > ArgW) ? AW : ArgW;

  localparam logic [3:0] S_FILL  = 4'd0;
  localparam logic [3:0] S_SRD   = 4'd1;
  localparam logic [3:0] S_SCHK  = 4'd2;
  localparam logic [3:0] S_SMARK = 4'd3;
  localparam logic [3:0] S_IDLE  = 4'd4;
  localparam logic [3:0] S_QRD   = 4'd5;
  localparam logic [3:0] S_QCHK  = 4'd6;
  localparam logic [3:0] S_DIVGO = 4'd7;
  localparam logic [3:0] S_DIVW  = 4'd8;
  localparam logic [3:0] S_MULGO = 4'd9;
  localparam logic [3:0] S_MULW  = 4'd10;

  logic [3:0]      state_r, state_nxt;
  logic [AW:0]     fill_r, fill_nxt;
  logic [AW-1:0]   si_r, si_nxt;
  logic [AW:0]     sj_r, sj_nxt;
  arg_t            n_r, n_nxt;
  arg_t            k_r, k_nxt;
  arg_t            q_r, q_nxt;
  arg_t            a_r, a_nxt;
  arg_t            b_r, b_nxt;
  arg_t            c_r, c_nxt;
  logic [ExpW-1:0] ex_r, ex_nxt;
  res_t            prod_r, prod_nxt;
  logic            ov_r, ov_nxt;
  res_t            obm_r, obm_nxt;
  logic            obad_r, obad_nxt;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic            wdata, rdata;
  logic [2*AW-1:0] sq;
  logic [XW-1:0]   q_ext;
  arg_t            term;
  logic [ExpW-1:0] ex_sum;
  div_req_t        dreq;
  div_rsp_t        drsp;
  logic            mgo, mdone;
  res_t            mres;

  bmp_ram #(.Width(1), .Depth(N_MAX)) u_flags (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  bmp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  bmp_mulmod u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (mgo),
    .a     (prod_r),
    .b     (q_r),
    .done  (mdone),
    .res   (mres)
  );

  assign sq     = {AW'(0), si_r} * {AW'(0), si_r};
  assign q_ext  = XW'(q_r);
  assign raddr  = (state_r == S_SRD) ? si_r : q_ext[AW-1:0];
  assign term   = drsp.quotient[0] - drsp.quotient[1] - drsp.quotient[2];
  assign ex_sum = ex_r + term[ExpW-1:0];

  assign dreq.go          = (state_r == S_DIVGO);
  assign dreq.divisor     = q_r;
  assign dreq.dividend[0] = a_r;
  assign dreq.dividend[1] = b_r;
  assign dreq.dividend[2] = c_r;
  assign mgo              = (state_r == S_MULGO);

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    si_nxt    = si_r;
    sj_nxt    = sj_r;
    n_nxt     = n_r;
    k_nxt     = k_r;
    q_nxt     = q_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    c_nxt     = c_r;
    ex_nxt    = ex_r;
    prod_nxt  = prod_r;
    ov_nxt    = 1'b0;
    obm_nxt   = obm_r;
    obad_nxt  = obad_r;
    we        = 1'b0;
    waddr     = fill_r[AW-1:0];
    wdata     = (fill_r >= (AW+1)'(2));
    case (state_r)
      S_FILL: begin
        we       = 1'b1;
        fill_nxt = fill_r + 1'b1;
        if (fill_r == (AW+1)'(N_MAX - 1)) begin
          si_nxt    = AW'(2);
          state_nxt = S_SRD;
        end
      end
      S_SRD: begin
        state_nxt = S_SCHK;
      end
      S_SCHK: begin
        if ({1'b0, sq} >= (2*AW+1)'(N_MAX)) begin
          state_nxt = S_IDLE;
        end else if (rdata) begin
          sj_nxt    = sq[AW:0];
          state_nxt = S_SMARK;
        end else begin
          si_nxt    = si_r + 1'b1;
          state_nxt = S_SRD;
        end
      end
      S_SMARK: begin
        we    = 1'b1;
        waddr = sj_r[AW-1:0];
        wdata = 1'b0;
        sj_nxt = sj_r + {1'b0, si_r};
        if (sj_nxt >= (AW+1)'(N_MAX)) begin
          si_nxt    = si_r + 1'b1;
          state_nxt = S_SRD;
        end
      end
      S_IDLE: begin
        if (start) begin
          if ((in_k_chosen > in_n_total) ||
              ({3'b000, in_n_total} >= 21'(N_MAX))) begin
            ov_nxt   = 1'b1;
            obm_nxt  = '0;
            obad_nxt = 1'b1;
          end else if (in_n_total < ArgW'(2)) begin
            ov_nxt   = 1'b1;
            obm_nxt  = ResW'(1);
            obad_nxt = 1'b0;
            prod_nxt = ResW'(1);
          end else begin
            n_nxt     = in_n_total;
            k_nxt     = in_k_chosen;
            q_nxt     = ArgW'(2);
            prod_nxt  = ResW'(1);
            state_nxt = S_QRD;
          end
        end
      end
      S_QRD: begin
        state_nxt = S_QCHK;
      end
      S_QCHK: begin
        if (rdata) begin
          a_nxt     = n_r;
          b_nxt     = k_r;
          c_nxt     = n_r - k_r;
          ex_nxt    = '0;
          state_nxt = S_DIVGO;
        end else begin
          state_nxt = S_QRD;
        end
      end
      S_DIVGO: begin
        state_nxt = S_DIVW;
      end
      S_DIVW: begin
        if (drsp.done) begin
          ex_nxt = ex_sum;
          a_nxt  = drsp.quotient[0];
          b_nxt  = drsp.quotient[1];
          c_nxt  = drsp.quotient[2];
          if (drsp.quotient[0] >= q_r) begin
            state_nxt = S_DIVGO;
          end else if (ex_sum != '0) begin
            state_nxt = S_MULGO;
          end else begin
            state_nxt = S_QRD;
          end
        end
      end
      S_MULGO: begin
        state_nxt = S_MULW;
      end
      S_MULW: begin
        if (mdone) begin
          prod_nxt = mres;
          ex_nxt   = ex_r - 1'b1;
          if (ex_r == ExpW'(1)) begin
            state_nxt = S_QRD;
          end else begin
            state_nxt = S_MULGO;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // Leaving a prime, or a composite: step to the next q or finish.
    if ((state_r == S_QCHK || state_r == S_DIVW || state_r == S_MULW) &&
        state_nxt == S_QRD) begin
      if (q_r == n_r) begin
        ov_nxt    = 1'b1;
        obm_nxt   = prod_nxt;
        obad_nxt  = 1'b0;
        q_nxt     = ArgW'(2);
        state_nxt = S_IDLE;
      end else begin
        q_nxt = q_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_FILL;
      fill_r  <= '0;
      q_r     <= ArgW'(2);
      prod_r  <= ResW'(1);
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      q_r     <= q_nxt;
      prod_r  <= prod_nxt;
      ov_r    <= ov_nxt;
    end
    si_r   <= si_nxt;
    sj_r   <= sj_nxt;
    n_r    <= n_nxt;
    k_r    <= k_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    c_r    <= c_nxt;
    ex_r   <= ex_nxt;
    obm_r  <= obm_nxt;
    obad_r <= obad_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = ov_r;
  assign out_binom_mod = obm_r;
  assign out_bad_args  = obad_r;

  a_prod_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    prod_r < MOD_P)
    else $error("running product left the residue range");

  a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_args) |-> (out_binom_mod == '0))
    else $error("rejected query returned a nonzero value");

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_QRD || state_r == S_DIVGO || state_r == S_MULGO) |-> (q_r <= n_r))
    else $error("prime cursor walked past n");

endmodule
